[rtl/tcmfg_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package tcmfg_pkg;

    localparam int SYNC_BYTES = 50;

    localparam int BYTE_CNT_W = 7;
    localparam int HALF_CNT_W = 4;

    localparam logic [7:0] SYNC_PATTERN = 8'hFF;
    localparam logic [7:0] START_SHIFT  = 8'hFE;
    localparam logic [HALF_CNT_W-1:0] LOAD_POINT = 4'd14;

    localparam logic [1:0] ACT_TICK  = 2'd0;
    localparam logic [1:0] ACT_FALL  = 2'd1;
    localparam logic [1:0] ACT_RISE  = 2'd2;
    localparam logic [1:0] ACT_WRITE = 2'd3;

    typedef struct packed {
        logic [7:0] data_value;
        logic [3:0] data_index;
        logic [1:0] action;
    } item_t;

    typedef struct packed {
        logic frame_end;
        logic busy_res;
        logic line_level;
    } result_t;

endpackage
`default_nettype wire

[rtl/time_code_manchester_frame_generator.sv]
// an accepted input beat passes the input register, then the core result register, to m_tvalid
// throughput: one beat per cycle unless m_tready stalls the output, every input beat gives exactly one result beat
// the half-bit tick update is one counter and shift step, done in the core stage
// reset: synchronous active-low aresetn clears the generator, output_enable and
// both valid stages; the data bytes are not cleared and must be written first
`timescale 1ns / 1ps
`default_nettype none
module time_code_manchester_frame_generator #(
    parameter int DATA_BYTES = 14
) (
    input  wire        aclk,
    input  wire        aresetn,
    input  wire        cfg_wr_en,
    input  wire        cfg_wr_data,   // output_enable
    input  wire        s_tvalid,
    output logic       s_tready,
    input  wire [1:0]  s_tuser,       // action[1:0]
    input  wire [15:0] s_tdata,       // data_index[3:0], data_value[11:4]
    output logic       m_tvalid,
    input  wire        m_tready,
    output logic [7:0] m_tdata,       // line_level[0], busy_res[1]
    output logic       m_tlast        // frame_end
);
    import tcmfg_pkg::*;

    logic    output_enable_reg;
    item_t   s_item;
    item_t   d_item;
    logic    d_valid;
    logic    d_ready;
    result_t m_result;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            output_enable_reg <= 1'b0;
        end else if (cfg_wr_en) begin
            output_enable_reg <= cfg_wr_data;
        end
    end

    assign s_item.action     = s_tuser;
    assign s_item.data_index = s_tdata[3:0];
    assign s_item.data_value = s_tdata[11:4];

    tcmfg_in_reg u_in_reg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .s_item  (s_item),
        .d_valid (d_valid),
        .d_ready (d_ready),
        .d_item  (d_item)
    );

    tcmfg_core #(
        .DATA_BYTES (DATA_BYTES)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .output_enable (output_enable_reg),
        .d_valid       (d_valid),
        .d_ready       (d_ready),
        .d_item        (d_item),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .m_result      (m_result)
    );

    assign m_tdata = {6'b000000, m_result.busy_res, m_result.line_level};
    assign m_tlast = m_result.frame_end;

endmodule
`default_nettype wire

[rtl/tcmfg_in_reg.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcmfg_in_reg (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  s_valid,
    output logic                 s_ready,
    input  tcmfg_pkg::item_t     s_item,
    output logic                 d_valid,
    input  wire                  d_ready,
    output tcmfg_pkg::item_t     d_item
);
    import tcmfg_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    assign s_ready = !valid_reg || d_ready;
    assign d_valid = valid_reg;
    assign d_item  = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (s_ready) begin
            valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            item_reg <= s_item;
        end
    end

endmodule
`default_nettype wire

[rtl/tcmfg_core.sv]
`timescale 1ns / 1ps
`default_nettype none
module tcmfg_core #(
    parameter int DATA_BYTES = 14
) (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  output_enable,
    input  wire                  d_valid,
    output logic                 d_ready,
    input  tcmfg_pkg::item_t     d_item,
    output logic                 m_valid,
    input  wire                  m_ready,
    output tcmfg_pkg::result_t   m_result
);
    import tcmfg_pkg::*;

    localparam int IDX_W = (DATA_BYTES > 1) ? $clog2(DATA_BYTES) : 1;

    logic [7:0]            data_store [DATA_BYTES];
    logic [7:0]            shift_reg, shift_next;
    logic [HALF_CNT_W-1:0] half_cnt_reg, half_cnt_next;
    logic [BYTE_CNT_W-1:0] byte_cnt_reg, byte_cnt_next;
    logic                  pending_reg, pending_next;
    logic                  running_reg, running_next;
    logic                  line_reg, line_next;
    logic                  m_valid_reg;
    result_t               result_reg;

    logic                  proc;
    logic                  ended;
    logic [7:0]            load_byte;
    logic [BYTE_CNT_W-1:0] data_pos;
    logic [5:0]            wr_idx;
    logic                  wr_en;

    assign d_ready  = !m_valid_reg || m_ready;
    assign proc     = d_valid && d_ready;
    assign m_valid  = m_valid_reg;
    assign m_result = result_reg;

    assign data_pos = byte_cnt_reg - BYTE_CNT_W'(SYNC_BYTES);
    assign wr_idx   = {2'b00, d_item.data_index};
    assign wr_en    = proc && (d_item.action == ACT_WRITE)
                      && (wr_idx < 6'(DATA_BYTES));

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            data_store[wr_idx[IDX_W-1:0]] <= d_item.data_value;
        end
    end

    always_comb begin
        shift_next    = shift_reg;
        half_cnt_next = half_cnt_reg;
        byte_cnt_next = byte_cnt_reg;
        pending_next  = pending_reg;
        running_next  = running_reg;
        line_next     = line_reg;
        ended         = 1'b0;
        load_byte     = shift_reg;
        if (proc) begin
            case (d_item.action)
                ACT_TICK: begin
                    if (output_enable && running_reg) begin
                        line_next = pending_reg;
                        if (half_cnt_reg[0]) begin
                            pending_next = !pending_reg;
                        end else begin
                            // byte boundary: reload from sync, data, or end the frame
                            if (half_cnt_reg >= LOAD_POINT) begin
                                if (byte_cnt_reg < BYTE_CNT_W'(SYNC_BYTES)) begin
                                    load_byte = SYNC_PATTERN;
                                end else if (byte_cnt_reg <
                                             BYTE_CNT_W'(SYNC_BYTES + DATA_BYTES)) begin
                                    load_byte = data_store[data_pos[IDX_W-1:0]];
                                end else begin
                                    line_next    = 1'b0;
                                    running_next = 1'b0;
                                    ended        = 1'b1;
                                end
                                byte_cnt_next = byte_cnt_reg + BYTE_CNT_W'(1);
                            end
                            pending_next = load_byte[7];
                            shift_next   = {load_byte[6:0], 1'b0};
                        end
                        half_cnt_next = half_cnt_reg + HALF_CNT_W'(1);
                    end
                end
                ACT_FALL: begin
                    if (output_enable) begin
                        line_next     = 1'b1;
                        running_next  = 1'b1;
                        pending_next  = 1'b0;
                        shift_next    = START_SHIFT;
                        byte_cnt_next = BYTE_CNT_W'(1);
                        half_cnt_next = '0;
                    end
                end
                ACT_RISE: begin
                    if (output_enable) begin
                        line_next = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg    <= '0;
            half_cnt_reg <= '0;
            byte_cnt_reg <= '0;
            pending_reg  <= 1'b0;
            running_reg  <= 1'b0;
            line_reg     <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            shift_reg    <= shift_next;
            half_cnt_reg <= half_cnt_next;
            byte_cnt_reg <= byte_cnt_next;
            pending_reg  <= pending_next;
            running_reg  <= running_next;
            line_reg     <= line_next;
            if (d_ready) begin
                m_valid_reg <= d_valid;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (proc) begin
            result_reg.line_level <= line_next;
            result_reg.busy_res   <= running_next;
            result_reg.frame_end  <= ended;
        end
    end

    a_end_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && result_reg.frame_end) |-> (!result_reg.busy_res
                                                   && !result_reg.line_level))
        else $error("frame end beat with busy or high line");

    a_fall_marks_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $fell(running_reg) |-> (m_valid_reg && result_reg.frame_end))
        else $error("generator stopped without a frame end beat");

    a_busy_tracks: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (result_reg.busy_res == running_reg
                         && result_reg.line_level == line_reg))
        else $error("held result disagrees with generator state");

    a_idle_frozen: assert property (@(posedge aclk) disable iff (!aresetn)
        (!running_reg && !(proc && d_item.action == ACT_FALL))
            |=> $stable(half_cnt_reg))
        else $error("half-bit counter moved while idle");

endmodule
`default_nettype wire

[dv/tb_time_code_manchester_frame_generator.sv]
`timescale 1ns / 1ps
module tb_time_code_manchester_frame_generator;
    import tcmfg_pkg::*;

    localparam int FRAME_DATA       = 14;
    localparam int RANDOM_BEATS     = 1950;
    localparam int FULL_FRAME_TICKS = 1100;
    localparam int DIRECTED_ROWS    = 25;

    localparam result_t RES_IDLE_LOW = '{frame_end: 1'b0, busy_res: 1'b0, line_level: 1'b0};
    localparam result_t RES_START    = '{frame_end: 1'b0, busy_res: 1'b1, line_level: 1'b1};
    localparam result_t RES_RUN_LOW  = '{frame_end: 1'b0, busy_res: 1'b1, line_level: 1'b0};

    typedef struct {
        logic    en;
        item_t   it;
        logic    pinned;
        result_t res;
    } directed_row_t;

    logic       aclk        = 1'b0;
    logic       aresetn     = 1'b0;
    logic       cfg_wr_en   = 1'b0;
    logic       cfg_wr_data = 1'b0;
    logic       s_tvalid    = 1'b0;
    logic       s_tready;
    logic [1:0] s_tuser     = '0;
    logic [15:0] s_tdata    = '0;
    logic       m_tvalid;
    logic       m_tready    = 1'b0;
    logic [7:0] m_tdata;
    logic       m_tlast;

    // typed expectation travels with the beat it belongs to
    logic    pin_valid = 1'b0;
    result_t pin_res   = '0;
    logic    quiet     = 1'b0;
    logic    drive_en  = 1'b0;

    // generator state as the predictor sees it
    logic [7:0] gen_bytes [FRAME_DATA];
    logic [7:0] gen_shift;
    logic [3:0] gen_half;
    logic [6:0] gen_byte_cnt;
    logic       gen_pend;
    logic       gen_run;
    logic       gen_line;
    logic       gen_en;

    result_t expected_line_q [$];
    int errors      = 0;
    int beats_in    = 0;
    int beats_out   = 0;
    int frames_done = 0;
    int rx_stall    = 0;

    directed_row_t dir_rows [DIRECTED_ROWS] = '{
        '{1'b0, '{8'h00, 4'd0,  ACT_TICK},  1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h00, 4'd0,  ACT_FALL},  1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h00, 4'd0,  ACT_RISE},  1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h00, 4'd0,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'hFF, 4'd1,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'hA5, 4'd2,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h5A, 4'd3,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h80, 4'd4,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h01, 4'd5,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h3C, 4'd6,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'hC3, 4'd7,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h7E, 4'd8,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h81, 4'd9,  ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h0F, 4'd10, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'hF0, 4'd11, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h96, 4'd12, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'hFF, 4'd13, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        // out of range positions, dropped
        '{1'b0, '{8'hFF, 4'd14, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b0, '{8'h00, 4'd15, ACT_WRITE}, 1'b1, RES_IDLE_LOW},
        '{1'b1, '{8'h00, 4'd0,  ACT_FALL},  1'b1, RES_START},
        '{1'b1, '{8'h00, 4'd0,  ACT_TICK},  1'b1, RES_RUN_LOW},
        '{1'b1, '{8'h00, 4'd0,  ACT_TICK},  1'b0, RES_IDLE_LOW},
        '{1'b1, '{8'h00, 4'd0,  ACT_RISE},  1'b1, RES_RUN_LOW},
        // restart in the middle of a frame
        '{1'b1, '{8'h00, 4'd0,  ACT_FALL},  1'b1, RES_START},
        '{1'b1, '{8'h00, 4'd0,  ACT_TICK},  1'b0, RES_IDLE_LOW}
    };

    time_code_manchester_frame_generator #(
        .DATA_BYTES(FRAME_DATA)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tuser    (s_tuser),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    function automatic result_t step_generator(input item_t it);
        result_t r;
        logic    ended;
        ended = 1'b0;
        case (it.action)
            ACT_TICK: begin
                if (gen_en && gen_run) begin
                    gen_line = gen_pend;
                    if (gen_half[0]) begin
                        gen_pend = ~gen_pend;
                    end else begin
                        // byte boundary: sync byte, data byte or end of frame
                        if (gen_half >= LOAD_POINT) begin
                            if (gen_byte_cnt < SYNC_BYTES) begin
                                gen_shift = SYNC_PATTERN;
                            end else if (gen_byte_cnt < SYNC_BYTES + FRAME_DATA) begin
                                gen_shift = gen_bytes[gen_byte_cnt - SYNC_BYTES];
                            end else begin
                                gen_line = 1'b0;
                                gen_run  = 1'b0;
                                ended    = 1'b1;
                            end
                            gen_byte_cnt = gen_byte_cnt + 7'd1;
                        end
                        gen_pend  = gen_shift[7];
                        gen_shift = gen_shift << 1;
                    end
                    gen_half = gen_half + 4'd1;
                end
            end
            ACT_FALL: begin
                if (gen_en) begin
                    gen_line     = 1'b1;
                    gen_run      = 1'b1;
                    gen_pend     = 1'b0;
                    gen_shift    = START_SHIFT;
                    gen_byte_cnt = 7'd1;
                    gen_half     = '0;
                end
            end
            ACT_RISE: begin
                if (gen_en) gen_line = 1'b0;
            end
            default: begin
                if (it.data_index < FRAME_DATA) gen_bytes[it.data_index] = it.data_value;
            end
        endcase
        r.line_level = gen_line;
        r.busy_res   = gen_run;
        r.frame_end  = ended;
        return r;
    endfunction

    always @(posedge aclk) begin : scoreboard
        result_t pred;
        result_t got;
        result_t want;
        if (!aresetn) begin
            gen_shift    = '0;
            gen_half     = '0;
            gen_byte_cnt = '0;
            gen_pend     = 1'b0;
            gen_run      = 1'b0;
            gen_line     = 1'b0;
            gen_en       = 1'b0;
            expected_line_q.delete();
        end else begin
            if (cfg_wr_en) gen_en = cfg_wr_data;
            if (s_tvalid && s_tready) begin
                pred = step_generator(item_t'({s_tdata[11:0], s_tuser}));
                expected_line_q.push_back(pin_valid ? pin_res : pred);
                beats_in++;
                if (pred.frame_end) frames_done++;
            end
            if (m_tvalid && m_tready) begin
                got.line_level = m_tdata[0];
                got.busy_res   = m_tdata[1];
                got.frame_end  = m_tlast;
                beats_out++;
                if (expected_line_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat, actual line/busy/end %0b%0b%0b",
                             $time, got.line_level, got.busy_res, got.frame_end);
                end else begin
                    want = expected_line_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        $display("%0t: mismatch, expected line/busy/end %0b%0b%0b, actual %0b%0b%0b",
                                 $time, want.line_level, want.busy_res, want.frame_end,
                                 got.line_level, got.busy_res, got.frame_end);
                    end
                end
            end
        end
    end

    // receiver backpressure in bursts
    always @(posedge aclk) begin
        if (rx_stall > 0) begin
            rx_stall <= rx_stall - 1;
            m_tready <= (rx_stall == 1);
        end else if (!quiet && $urandom_range(0, 11) == 0) begin
            rx_stall <= $urandom_range(1, 19);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    task automatic send_beat(input item_t it, input logic pinned, input result_t res);
        int gap;
        gap = 0;
        if (!quiet && $urandom_range(0, 13) == 0) gap = $urandom_range(1, 19);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid  <= 1'b1;
        s_tuser   <= it.action;
        s_tdata   <= {4'b0000, it.data_value, it.data_index};
        pin_valid <= pinned;
        pin_res   <= res;
        do @(posedge aclk); while (!s_tready);
    endtask

    // hold the sender until every result is back, then write output_enable
    task automatic drain_and_enable(input logic en);
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_line_q.size() != 0) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= en;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        drive_en = en;
    endtask

    function automatic item_t frame_item(input int noise_pct, input logic allow_fall);
        item_t it;
        it.data_index = $urandom_range(0, 15);
        it.data_value = $urandom_range(0, 255);
        it.action     = ACT_TICK;
        if ($urandom_range(0, 99) < noise_pct) begin
            case ($urandom_range(0, 2))
                0: it.action = ACT_RISE;
                1: it.action = ACT_WRITE;
                default: it.action = allow_fall ? ACT_FALL : ACT_WRITE;
            endcase
        end
        return it;
    endfunction

    initial begin : stimulus
        item_t it;
        int    sent;
        int    kind;
        int    len;
        logic  first;
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        drain_and_enable(dir_rows[0].en);

        for (int i = 0; i < DIRECTED_ROWS; i++) begin
            if (dir_rows[i].en != drive_en) drain_and_enable(dir_rows[i].en);
            send_beat(dir_rows[i].it, dir_rows[i].pinned, dir_rows[i].res);
        end

        sent  = 0;
        first = 1'b1;
        while (sent < RANDOM_BEATS) begin
            quiet <= (sent > RANDOM_BEATS * 17 / 20) || ($urandom_range(0, 3) == 0);
            kind  = first ? 0 : $urandom_range(0, 9);
            first = 1'b0;
            if (kind <= 2 && sent + FULL_FRAME_TICKS < RANDOM_BEATS) begin
                // whole frame: sync, data and the closing tick, no restarts
                if (!drive_en) drain_and_enable(1'b1);
                it = frame_item(0, 1'b0);
                it.action = ACT_FALL;
                send_beat(it, 1'b0, RES_IDLE_LOW);
                repeat (FULL_FRAME_TICKS) send_beat(frame_item(3, 1'b0), 1'b0, RES_IDLE_LOW);
                sent += FULL_FRAME_TICKS + 1;
            end else if (kind <= 5) begin
                if (!drive_en) drain_and_enable(1'b1);
                len = $urandom_range(1, 200);
                it = frame_item(0, 1'b0);
                it.action = ACT_FALL;
                send_beat(it, 1'b0, RES_IDLE_LOW);
                repeat (len) send_beat(frame_item(8, 1'b1), 1'b0, RES_IDLE_LOW);
                sent += len + 1;
            end else if (kind == 6) begin
                // pause a running frame, everything but writes is dropped
                drain_and_enable(1'b0);
                len = $urandom_range(5, 30);
                repeat (len) begin
                    it = frame_item(0, 1'b0);
                    it.action = 2'($urandom_range(0, 3));
                    send_beat(it, 1'b0, RES_IDLE_LOW);
                end
                drain_and_enable(1'b1);
                sent += len;
            end else begin
                if ($urandom_range(0, 3) == 0) drain_and_enable(1'($urandom_range(0, 1)));
                len = $urandom_range(5, 40);
                repeat (len) begin
                    it = frame_item(0, 1'b0);
                    it.action = 2'($urandom_range(0, 3));
                    send_beat(it, 1'b0, RES_IDLE_LOW);
                end
                sent += len;
            end
        end

        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_line_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);

        $display("checked %0d result beats for %0d input beats, %0d frames sent to the end",
                 beats_out, beats_in, frames_done);
        $display("frames included restarts, pauses while disabled and data rewrites mid-frame");
        if (errors == 0 && expected_line_q.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    initial begin : watchdog
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
rtl/tcmfg_pkg.sv
rtl/tcmfg_in_reg.sv
rtl/tcmfg_core.sv
rtl/time_code_manchester_frame_generator.sv
dv/tb_time_code_manchester_frame_generator.sv
